// ===== src/lsrv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsrv_pkg: shared types and constants for the stack with remove by value
// Opcodes, status codes, controller states and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lsrv_pkg;

  localparam int unsigned DEPTH_DEF = 128;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DEPTH_W   = 8;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOTFOUND  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SRCH,
    S_SHIFT
  } state_e;

  // read address sources
  typedef enum logic [1:0] {
    RA_TOP,
    RA_PTR_DN,
    RA_PTR_UP1,
    RA_PTR_UP2
  } rsel_e;

  // write address and data source: push at the top, or shift one place down
  typedef enum logic {
    WA_PUSH,
    WA_SHIFT
  } wsel_e;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_TOP,
    PTR_DEC,
    PTR_INC
  } ptr_e;

  typedef enum logic [1:0] {
    OV_ZERO,
    OV_RDATA,
    OV_VALUE
  } ovsel_e;

  typedef struct packed {
    logic    latch;
    logic    mem_we;
    wsel_e   wsel;
    logic    rd_en;
    rsel_e   rsel;
    ptr_e    ptr_op;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
    status_e out_status;
    ovsel_e  ov_sel;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic match;
    logic ptr_zero;
    logic ptr_top;
    logic nxt_top;
    logic slot_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== src/lsrv_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsrv_ctrl: sequencer for the stack
// Steps push, pop and the downward search and shift of remove, issuing
// one command word to the datapath each cycle.
// ----------------------------------------------------------------------------
module lsrv_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire lsrv_pkg::stat_t stat_i,
  output lsrv_pkg::cmd_t       cmd_o
);

  lsrv_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsrv_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != lsrv_pkg::S_IDLE);

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.wsel        = lsrv_pkg::WA_PUSH;
    cmd_o.rsel        = lsrv_pkg::RA_TOP;
    cmd_o.ptr_op      = lsrv_pkg::PTR_HOLD;
    cmd_o.out_status  = lsrv_pkg::ST_OK;
    cmd_o.ov_sel      = lsrv_pkg::OV_ZERO;
    case (state_q)
      lsrv_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = lsrv_pkg::S_EXEC;
        end
      end
      lsrv_pkg::S_EXEC: begin
        // hold until the result register can take this transaction
        if (stat_i.slot_free) begin
          case (stat_i.op)
            lsrv_pkg::OP_PUSH: begin
              cmd_o.out_load = 1'b1;
              state_d        = lsrv_pkg::S_IDLE;
              if (stat_i.full) begin
                cmd_o.out_status = lsrv_pkg::ST_OVERFLOW;
              end else begin
                cmd_o.mem_we  = 1'b1;
                cmd_o.wsel    = lsrv_pkg::WA_PUSH;
                cmd_o.cnt_inc = 1'b1;
              end
            end
            lsrv_pkg::OP_POP: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = lsrv_pkg::ST_UNDERFLOW;
                state_d          = lsrv_pkg::S_IDLE;
              end else begin
                cmd_o.rd_en   = 1'b1;
                cmd_o.rsel    = lsrv_pkg::RA_TOP;
                cmd_o.cnt_dec = 1'b1;
                state_d       = lsrv_pkg::S_POP;
              end
            end
            lsrv_pkg::OP_REMOVE: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = lsrv_pkg::ST_NOTFOUND;
                state_d          = lsrv_pkg::S_IDLE;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rsel   = lsrv_pkg::RA_TOP;
                cmd_o.ptr_op = lsrv_pkg::PTR_TOP;
                state_d      = lsrv_pkg::S_SRCH;
              end
            end
            default: begin
              cmd_o.out_load = 1'b1;
              state_d        = lsrv_pkg::S_IDLE;
            end
          endcase
        end
      end
      lsrv_pkg::S_POP: begin
        cmd_o.out_load = 1'b1;
        cmd_o.ov_sel   = lsrv_pkg::OV_RDATA;
        state_d        = lsrv_pkg::S_IDLE;
      end
      lsrv_pkg::S_SRCH: begin
        if (stat_i.match) begin
          if (stat_i.ptr_top) begin
            cmd_o.cnt_dec  = 1'b1;
            cmd_o.out_load = 1'b1;
            cmd_o.ov_sel   = lsrv_pkg::OV_VALUE;
            state_d        = lsrv_pkg::S_IDLE;
          end else begin
            cmd_o.rd_en = 1'b1;
            cmd_o.rsel  = lsrv_pkg::RA_PTR_UP1;
            state_d     = lsrv_pkg::S_SHIFT;
          end
        end else if (stat_i.ptr_zero) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = lsrv_pkg::ST_NOTFOUND;
          state_d          = lsrv_pkg::S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rsel   = lsrv_pkg::RA_PTR_DN;
          cmd_o.ptr_op = lsrv_pkg::PTR_DEC;
        end
      end
      lsrv_pkg::S_SHIFT: begin
        // entry above the pointer is in the read register: move it down
        cmd_o.mem_we = 1'b1;
        cmd_o.wsel   = lsrv_pkg::WA_SHIFT;
        if (stat_i.nxt_top) begin
          cmd_o.cnt_dec  = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.ov_sel   = lsrv_pkg::OV_VALUE;
          state_d        = lsrv_pkg::S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rsel   = lsrv_pkg::RA_PTR_UP2;
          cmd_o.ptr_op = lsrv_pkg::PTR_INC;
        end
      end
      default: begin
        state_d = lsrv_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/lsrv_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsrv_dpath: storage and result register for the stack
// Entry memory with one write and one registered read port, entry count,
// walk pointer, latched request and the output register.
// ----------------------------------------------------------------------------
module lsrv_dpath #(
  parameter int unsigned DEPTH = lsrv_pkg::DEPTH_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire  [1:0]                          opcode_i,
  input  wire  signed [lsrv_pkg::DATA_W-1:0]  value_i,
  input  wire lsrv_pkg::cmd_t                 cmd_i,
  output lsrv_pkg::stat_t                     stat_o,
  input  wire                                 out_stall_i,
  output logic                                out_valid_o,
  output logic [1:0]                          status_o,
  output logic signed [lsrv_pkg::DATA_W-1:0]  value_out_o,
  output logic [lsrv_pkg::DEPTH_W-1:0]        depth_out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [lsrv_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [lsrv_pkg::DATA_W-1:0] rdata_q;
  logic signed [lsrv_pkg::DATA_W-1:0] val_q;
  lsrv_pkg::op_e                      op_q;
  logic [CW-1:0]                      cnt_q, cnt_d;
  logic [AW-1:0]                      ptr_q, ptr_d;
  logic [AW-1:0]                      top_idx;
  logic [AW-1:0]                      raddr, waddr;
  logic signed [lsrv_pkg::DATA_W-1:0] wdata;
  logic                               out_valid_q;

  assign top_idx = AW'(cnt_q - CW'(1));

  always_comb begin
    case (cmd_i.rsel)
      lsrv_pkg::RA_TOP:     raddr = top_idx;
      lsrv_pkg::RA_PTR_DN:  raddr = ptr_q - AW'(1);
      lsrv_pkg::RA_PTR_UP1: raddr = ptr_q + AW'(1);
      lsrv_pkg::RA_PTR_UP2: raddr = ptr_q + AW'(2);
      default:              raddr = top_idx;
    endcase
  end

  always_comb begin
    case (cmd_i.wsel)
      lsrv_pkg::WA_PUSH: begin
        waddr = AW'(cnt_q);
        wdata = val_q;
      end
      lsrv_pkg::WA_SHIFT: begin
        waddr = ptr_q;
        wdata = rdata_q;
      end
      default: begin
        waddr = AW'(cnt_q);
        wdata = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= lsrv_pkg::op_e'(opcode_i);
      val_q <= value_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_comb begin
    case (cmd_i.ptr_op)
      lsrv_pkg::PTR_HOLD: ptr_d = ptr_q;
      lsrv_pkg::PTR_TOP:  ptr_d = top_idx;
      lsrv_pkg::PTR_DEC:  ptr_d = ptr_q - AW'(1);
      lsrv_pkg::PTR_INC:  ptr_d = ptr_q + AW'(1);
      default:            ptr_d = ptr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
    end
  end

  // result register: drop the valid once taken, reload on a finished transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o    <= cmd_i.out_status;
      depth_out_o <= lsrv_pkg::DEPTH_W'(cnt_d);
      case (cmd_i.ov_sel)
        lsrv_pkg::OV_ZERO:  value_out_o <= '0;
        lsrv_pkg::OV_RDATA: value_out_o <= rdata_q;
        lsrv_pkg::OV_VALUE: value_out_o <= val_q;
        default:            value_out_o <= '0;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;

  assign stat_o.op        = op_q;
  assign stat_o.full      = (cnt_q == CW'(DEPTH));
  assign stat_o.empty     = (cnt_q == '0);
  assign stat_o.match     = (rdata_q == val_q);
  assign stat_o.ptr_zero  = (ptr_q == '0);
  assign stat_o.ptr_top   = (ptr_q == top_idx);
  assign stat_o.nxt_top   = ((ptr_q + AW'(1)) == top_idx);
  assign stat_o.slot_free = !out_valid_q || !out_stall_i;

endmodule
`default_nettype wire

// ===== src/lifo_stack_remove_by_value.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lifo_stack_remove_by_value: bounded stack with remove by value
// Stack of signed 32-bit entries with push, pop and remove of the topmost
// entry equal to a given value.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries opcode_i and value_i;
//   a transaction is taken when valid is high and stall is low. Each one
//   gives exactly one result on the output channel (out_valid_o /
//   out_stall_i) with status, value and depth after the operation.
//   The request is registered, then executed. Push, unused opcode,
//   overflow, underflow and remove on an empty stack finish in the execute
//   step; pop reads the top entry there and loads the result in a pop step
//   after it, as the entry memory has a registered read port. Remove walks
//   down from the top one entry a cycle, then shifts the entries above the
//   match down one a cycle through the same single read and write port; a
//   remove that finds no match walks down to the bottom entry. A new request
//   is taken once the previous one has written its result register.
//   Stall: the result register holds while out_stall_i is high; a following
//   request is accepted and waits in its execute step until the register
//   frees. Reset empties the stack and drops any pending result; entry
//   contents are not cleared.
// ----------------------------------------------------------------------------
module lifo_stack_remove_by_value #(
  parameter int unsigned DEPTH = lsrv_pkg::DEPTH_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  [1:0]                          opcode_i,
  input  wire  signed [lsrv_pkg::DATA_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [1:0]                          status_o,
  output logic signed [lsrv_pkg::DATA_W-1:0]  value_out_o,
  output logic [lsrv_pkg::DEPTH_W-1:0]        depth_out_o
);

  lsrv_pkg::cmd_t  cmd;
  lsrv_pkg::stat_t stat;

  lsrv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lsrv_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .value_out_o (value_out_o),
    .depth_out_o (depth_out_o)
  );

endmodule
`default_nettype wire
